### hw/rtl/dfr_pkg.sv
// Shared constants, types and tables of the frequency response core.
`timescale 1ns / 1ps
`default_nettype none
package dfr_pkg;

    localparam int MAX_TAPS     = 32;
    localparam int PHASE_BITS   = 16;
    localparam int CORDIC_STEPS = 28;

    localparam int TAP_AW  = $clog2(MAX_TAPS);
    localparam int CNT_W   = $clog2(MAX_TAPS + 1);
    localparam int COEF_W  = 32;
    localparam int TRIG_W  = 33;
    localparam int PROD_W  = COEF_W + TRIG_W;
    localparam int ACC_W   = 35 + $clog2(MAX_TAPS);
    localparam int DEN_W   = 61;
    localparam int HNUM_W  = 64;
    localparam int RES_W   = 32;
    localparam int STEP_W  = 5;
    localparam int CFG_W   = 6;
    localparam int J_W     = 3;

    typedef enum logic [1:0] {
        ACT_LOAD_NUM = 2'd0,
        ACT_LOAD_DEN = 2'd1,
        ACT_EVAL     = 2'd2,
        ACT_NONE     = 2'd3
    } action_t;

    typedef enum logic [1:0] {
        STAT_OK       = 2'd0,
        STAT_DEN_NULL = 2'd1,
        STAT_DEN_ZERO = 2'd2
    } status_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_ANGLE,
        S_TRIG,
        S_MUL,
        S_MAG,
        S_SCALE,
        S_DMUL,
        S_DSTART,
        S_DWAIT,
        S_OUT
    } state_t;

    localparam logic REG_NUM_TAPS = 1'b0;
    localparam logic REG_DEN_TAPS = 1'b1;

    // arctangent of 2^-i in units of 2^-32 turn
    function automatic logic [31:0] atan_turn(input logic [STEP_W-1:0] i);
        logic [31:0] v;
        unique case (i)
            5'd0:  v = 32'd536870912;
            5'd1:  v = 32'd316933406;
            5'd2:  v = 32'd167458907;
            5'd3:  v = 32'd85004756;
            5'd4:  v = 32'd42667331;
            5'd5:  v = 32'd21354465;
            5'd6:  v = 32'd10679838;
            5'd7:  v = 32'd5340245;
            5'd8:  v = 32'd2670163;
            5'd9:  v = 32'd1335087;
            5'd10: v = 32'd667544;
            5'd11: v = 32'd333772;
            5'd12: v = 32'd166886;
            5'd13: v = 32'd83443;
            5'd14: v = 32'd41721;
            5'd15: v = 32'd20861;
            5'd16: v = 32'd10430;
            5'd17: v = 32'd5215;
            5'd18: v = 32'd2608;
            5'd19: v = 32'd1304;
            5'd20: v = 32'd652;
            5'd21: v = 32'd326;
            5'd22: v = 32'd163;
            5'd23: v = 32'd81;
            5'd24: v = 32'd41;
            5'd25: v = 32'd20;
            5'd26: v = 32'd10;
            5'd27: v = 32'd5;
            default: v = 32'd0;
        endcase
        return v;
    endfunction

    // tap count in use, capped at the store depth
    function automatic logic [CNT_W-1:0] taps_used(input logic [CFG_W-1:0] n);
        logic [CNT_W-1:0] v;
        if (int'(n) > MAX_TAPS) begin
            v = CNT_W'(MAX_TAPS);
        end else begin
            v = CNT_W'(n);
        end
        return v;
    endfunction

endpackage
`default_nettype wire

### hw/rtl/digital_frequency_response_core.sv
// Top level: tap stores, evaluation sequencer, shared multiplier and APB registers.
// Load transaction: written to the tap store at the edge that accepts it.
// Evaluate transaction: a 28-step CORDIC and the multiplies for each of K = max(numerator,
// denominator taps in use) taps, then S = 0..7 normalising shifts, before m_tvalid.
// One transaction at a time; a finished result waits in the output register.
// aresetn (synchronous, active low) clears control and sets both tap counts to 1;
// tap stores are not cleared and must be loaded before use.
`timescale 1ns / 1ps
`default_nettype none
module digital_frequency_response_core (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // input transaction
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // [4:0] tap_index, [36:5] coef_value, [52:37] frequency_phase, [55:53] zero
    input  wire logic [55:0] s_tdata,
    // [1:0] action
    input  wire logic [1:0]  s_tuser,
    // result transaction
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // [31:0] response_real, [63:32] response_imag
    output logic [63:0]      m_tdata,
    // [1:0] status
    output logic [1:0]       m_tuser,
    // configuration
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    localparam int PB = dfr_pkg::PHASE_BITS;
    localparam int AW = dfr_pkg::TAP_AW;
    localparam int CW = dfr_pkg::CNT_W;
    localparam int AC = dfr_pkg::ACC_W;
    localparam int PW = dfr_pkg::PROD_W;
    localparam logic signed [PW-1:0] HALF = PW'(1) << 29;

    // ---- input fields
    dfr_pkg::action_t           action;
    logic [4:0]                 tap_index;
    logic [31:0]                coef_value;
    logic [PB-1:0]              frequency_phase;
    logic                       in_acc, tap_ok;

    assign action          = dfr_pkg::action_t'(s_tuser);
    assign tap_index       = s_tdata[4:0];
    assign coef_value      = s_tdata[36:5];
    assign frequency_phase = s_tdata[37 +: PB];
    assign in_acc          = s_tvalid && s_tready;
    assign tap_ok          = int'(tap_index) < dfr_pkg::MAX_TAPS;

    // ---- configuration registers
    logic [dfr_pkg::CFG_W-1:0] num_taps_reg, den_taps_reg;

    assign pready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            num_taps_reg <= dfr_pkg::CFG_W'(1);
            den_taps_reg <= dfr_pkg::CFG_W'(1);
        end else if (psel && penable && pwrite) begin
            unique case (paddr[2])
                dfr_pkg::REG_NUM_TAPS: num_taps_reg <= pwdata[dfr_pkg::CFG_W-1:0];
                dfr_pkg::REG_DEN_TAPS: den_taps_reg <= pwdata[dfr_pkg::CFG_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[2])
            dfr_pkg::REG_NUM_TAPS: prdata = {26'b0, num_taps_reg};
            dfr_pkg::REG_DEN_TAPS: prdata = {26'b0, den_taps_reg};
            default: prdata = '0;
        endcase
    end

    // ---- tap stores, read at the current tap
    logic [CW-1:0]     k_reg;
    logic [31:0]       num_rdata, den_rdata;

    dfr_tap_ram #(.DEPTH(dfr_pkg::MAX_TAPS), .WIDTH(32)) u_num_ram (
        .aclk  (aclk),
        .we    (in_acc && action == dfr_pkg::ACT_LOAD_NUM && tap_ok),
        .waddr (AW'(tap_index)),
        .wdata (coef_value),
        .raddr (k_reg[AW-1:0]),
        .rdata (num_rdata)
    );

    dfr_tap_ram #(.DEPTH(dfr_pkg::MAX_TAPS), .WIDTH(32)) u_den_ram (
        .aclk  (aclk),
        .we    (in_acc && action == dfr_pkg::ACT_LOAD_DEN && tap_ok),
        .waddr (AW'(tap_index)),
        .wdata (coef_value),
        .raddr (k_reg[AW-1:0]),
        .rdata (den_rdata)
    );

    // ---- state
    dfr_pkg::state_t state_reg, state_next;
    logic            cordic_start, cordic_done, div_start, div_done_r, div_done_i;
    logic signed [dfr_pkg::TRIG_W-1:0] cos_v, sin_v;

    logic [CW-1:0]   nn_reg, nd_reg, kmax_reg, kmax_in;
    logic [PB-1:0]   ph_reg, step_reg;
    logic [dfr_pkg::J_W-1:0] j_reg;
    logic            nz_reg;

    logic signed [AC-1:0] nr_reg, ni_reg, dr_reg, di_reg;   // sums
    logic signed [AC-1:0] snr_reg, sni_reg, sdr_reg, sdi_reg; // normalised
    logic [AC-1:0]        m_reg;
    logic signed [dfr_pkg::HNUM_W-1:0] hrn_reg, hin_reg;
    logic [dfr_pkg::DEN_W-1:0]         dsq_reg;
    logic signed [PW-1:0]              prod_reg, rsum;
    logic signed [AC-1:0]              rnd_term;

    logic signed [dfr_pkg::COEF_W-1:0] mul_a;
    logic signed [dfr_pkg::TRIG_W-1:0] mul_b;

    logic signed [dfr_pkg::RES_W-1:0]  res_re_reg, res_im_reg, quo_r, quo_i;
    dfr_pkg::status_t                  res_st_reg;
    logic                              m_valid_reg;
    logic [63:0]                       m_data_reg;
    logic [1:0]                        m_user_reg;

    logic loop_last, num_on, den_on, scale_more, den_zero;
    logic [AC-1:0] a_nr, a_ni, a_dr, a_di, mx0, mx1;

    assign kmax_in   = (dfr_pkg::taps_used(num_taps_reg) > dfr_pkg::taps_used(den_taps_reg))
                     ? dfr_pkg::taps_used(num_taps_reg) : dfr_pkg::taps_used(den_taps_reg);
    assign loop_last = CW'(k_reg + 1'b1) >= kmax_reg;
    assign num_on    = k_reg < nn_reg;
    assign den_on    = k_reg < nd_reg;
    assign scale_more = m_reg[AC-1:30] != '0;
    assign den_zero  = (sdr_reg == '0) && (sdi_reg == '0);

    assign a_nr = nr_reg[AC-1] ? AC'(-nr_reg) : AC'(nr_reg);
    assign a_ni = ni_reg[AC-1] ? AC'(-ni_reg) : AC'(ni_reg);
    assign a_dr = dr_reg[AC-1] ? AC'(-dr_reg) : AC'(dr_reg);
    assign a_di = di_reg[AC-1] ? AC'(-di_reg) : AC'(di_reg);
    assign mx0  = (a_nr > a_ni) ? a_nr : a_ni;
    assign mx1  = (a_dr > a_di) ? a_dr : a_di;

    dfr_cordic u_cordic (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (cordic_start),
        .angle   ({ph_reg, {(32 - PB){1'b0}}}),
        .done    (cordic_done),
        .cos_out (cos_v),
        .sin_out (sin_v)
    );

    dfr_divider u_div_re (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .num     (hrn_reg),
        .den     (dsq_reg),
        .done    (div_done_r),
        .quo     (quo_r)
    );

    dfr_divider u_div_im (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .num     (hin_reg),
        .den     (dsq_reg),
        .done    (div_done_i),
        .quo     (quo_i)
    );

    // ---- shared multiplier operand select
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        if (state_reg == dfr_pkg::S_MUL) begin
            unique case (j_reg)
                3'd0: begin mul_a = $signed(num_rdata); mul_b = cos_v;  end
                3'd1: begin mul_a = $signed(num_rdata); mul_b = -sin_v; end
                3'd2: begin mul_a = $signed(den_rdata); mul_b = cos_v;  end
                3'd3: begin mul_a = $signed(den_rdata); mul_b = -sin_v; end
                default: ;
            endcase
        end else begin
            unique case (j_reg)
                3'd0: begin mul_a = 32'(sdr_reg); mul_b = 33'(sdr_reg); end
                3'd1: begin mul_a = 32'(sdi_reg); mul_b = 33'(sdi_reg); end
                3'd2: begin mul_a = 32'(snr_reg); mul_b = 33'(sdr_reg); end
                3'd3: begin mul_a = 32'(sni_reg); mul_b = 33'(sdi_reg); end
                3'd4: begin mul_a = 32'(sni_reg); mul_b = 33'(sdr_reg); end
                3'd5: begin mul_a = 32'(snr_reg); mul_b = 33'(sdi_reg); end
                default: ;
            endcase
        end
    end

    // round to Q8.24: floor((p + 2^29) / 2^30)
    assign rsum     = prod_reg + HALF;
    assign rnd_term = AC'(rsum >>> 30);

    // ---- sequencer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= dfr_pkg::S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next   = state_reg;
        cordic_start = 1'b0;
        div_start    = 1'b0;
        unique case (state_reg)
            dfr_pkg::S_IDLE: begin
                if (in_acc && action == dfr_pkg::ACT_EVAL) begin
                    state_next = (kmax_in == '0) ? dfr_pkg::S_OUT : dfr_pkg::S_ANGLE;
                end
            end
            dfr_pkg::S_ANGLE: begin
                cordic_start = 1'b1;
                state_next   = dfr_pkg::S_TRIG;
            end
            dfr_pkg::S_TRIG: begin
                if (cordic_done) state_next = dfr_pkg::S_MUL;
            end
            dfr_pkg::S_MUL: begin
                if (j_reg == 3'd4) begin
                    if (!loop_last)  state_next = dfr_pkg::S_ANGLE;
                    else if (nz_reg) state_next = dfr_pkg::S_MAG;
                    else             state_next = dfr_pkg::S_OUT;
                end
            end
            dfr_pkg::S_MAG:   state_next = dfr_pkg::S_SCALE;
            dfr_pkg::S_SCALE: begin
                if (!scale_more) begin
                    state_next = den_zero ? dfr_pkg::S_OUT : dfr_pkg::S_DMUL;
                end
            end
            dfr_pkg::S_DMUL: begin
                if (j_reg == 3'd6) state_next = dfr_pkg::S_DSTART;
            end
            dfr_pkg::S_DSTART: begin
                div_start  = 1'b1;
                state_next = dfr_pkg::S_DWAIT;
            end
            dfr_pkg::S_DWAIT: begin
                if (div_done_r && div_done_i) state_next = dfr_pkg::S_OUT;
            end
            dfr_pkg::S_OUT: begin
                if (!m_valid_reg || m_tready) state_next = dfr_pkg::S_IDLE;
            end
            default: state_next = dfr_pkg::S_IDLE;
        endcase
    end

    // ---- datapath
    always_ff @(posedge aclk) begin
        unique case (state_reg)
            dfr_pkg::S_IDLE: begin
                k_reg    <= '0;
                ph_reg   <= '0;
                step_reg <= frequency_phase;
                nn_reg   <= dfr_pkg::taps_used(num_taps_reg);
                nd_reg   <= dfr_pkg::taps_used(den_taps_reg);
                kmax_reg <= kmax_in;
                nz_reg   <= 1'b0;
                nr_reg   <= '0;
                ni_reg   <= '0;
                dr_reg   <= '0;
                di_reg   <= '0;
                res_re_reg <= '0;
                res_im_reg <= '0;
                res_st_reg <= dfr_pkg::STAT_DEN_NULL;
            end
            dfr_pkg::S_TRIG: begin
                j_reg <= '0;
                if (cordic_done && den_on && den_rdata != '0) nz_reg <= 1'b1;
            end
            dfr_pkg::S_MUL: begin
                j_reg    <= j_reg + 1'b1;
                prod_reg <= PW'(mul_a) * PW'(mul_b);
                unique case (j_reg)
                    3'd1: if (num_on) nr_reg <= nr_reg + rnd_term;
                    3'd2: if (num_on) ni_reg <= ni_reg + rnd_term;
                    3'd3: if (den_on) dr_reg <= dr_reg + rnd_term;
                    3'd4: if (den_on) di_reg <= di_reg + rnd_term;
                    default: ;
                endcase
                if (j_reg == 3'd4) begin
                    k_reg  <= CW'(k_reg + 1'b1);
                    ph_reg <= ph_reg + step_reg;
                    // all denominator taps zero: result stays 0, status already set
                end
            end
            dfr_pkg::S_MAG: begin
                m_reg   <= (mx0 > mx1) ? mx0 : mx1;
                snr_reg <= nr_reg;
                sni_reg <= ni_reg;
                sdr_reg <= dr_reg;
                sdi_reg <= di_reg;
            end
            dfr_pkg::S_SCALE: begin
                j_reg   <= '0;
                dsq_reg <= '0;
                hrn_reg <= '0;
                hin_reg <= '0;
                if (scale_more) begin
                    m_reg   <= m_reg >> 1;
                    snr_reg <= snr_reg >>> 1;
                    sni_reg <= sni_reg >>> 1;
                    sdr_reg <= sdr_reg >>> 1;
                    sdi_reg <= sdi_reg >>> 1;
                end else if (den_zero) begin
                    // zero denominator: saturate by the sign of each numerator part
                    res_st_reg <= dfr_pkg::STAT_DEN_ZERO;
                    res_re_reg <= (nr_reg == '0) ? 32'sd0
                                : (nr_reg[AC-1] ? 32'sh8000_0000 : 32'sh7FFF_FFFF);
                    res_im_reg <= (ni_reg == '0) ? 32'sd0
                                : (ni_reg[AC-1] ? 32'sh8000_0000 : 32'sh7FFF_FFFF);
                end
            end
            dfr_pkg::S_DMUL: begin
                j_reg    <= j_reg + 1'b1;
                prod_reg <= PW'(mul_a) * PW'(mul_b);
                unique case (j_reg)
                    3'd1, 3'd2: dsq_reg <= dsq_reg + dfr_pkg::DEN_W'(prod_reg);
                    3'd3, 3'd4: hrn_reg <= hrn_reg + dfr_pkg::HNUM_W'(prod_reg);
                    3'd5:       hin_reg <= hin_reg + dfr_pkg::HNUM_W'(prod_reg);
                    3'd6:       hin_reg <= hin_reg - dfr_pkg::HNUM_W'(prod_reg);
                    default: ;
                endcase
            end
            dfr_pkg::S_DWAIT: begin
                if (div_done_r) begin
                    res_re_reg <= quo_r;
                    res_im_reg <= quo_i;
                    res_st_reg <= dfr_pkg::STAT_OK;
                end
            end
            default: ;
        endcase
    end

    // ---- output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            if (m_valid_reg && m_tready) m_valid_reg <= 1'b0;
            if (state_reg == dfr_pkg::S_OUT && (!m_valid_reg || m_tready)) begin
                m_valid_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == dfr_pkg::S_OUT && (!m_valid_reg || m_tready)) begin
            m_data_reg <= {res_im_reg, res_re_reg};
            m_user_reg <= res_st_reg;
        end
    end

    assign s_tready = state_reg == dfr_pkg::S_IDLE;
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_user_reg;

endmodule
`default_nettype wire

### hw/rtl/dfr_tap_ram.sv
// Single-port-write, registered-read coefficient store.
`timescale 1ns / 1ps
`default_nettype none
module dfr_tap_ram #(
    parameter int DEPTH = 32,
    parameter int WIDTH = 32,
    localparam int AW = $clog2(DEPTH)
) (
    input  wire logic             aclk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
`default_nettype wire

### hw/rtl/dfr_cordic.sv
// Iterative CORDIC giving cosine and sine in Q2.30, one step per cycle.
`timescale 1ns / 1ps
`default_nettype none
module dfr_cordic (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            start,
    input  wire logic [31:0]                     angle,
    output logic                                 done,
    output logic signed [dfr_pkg::TRIG_W-1:0]    cos_out,
    output logic signed [dfr_pkg::TRIG_W-1:0]    sin_out
);

    localparam logic signed [dfr_pkg::TRIG_W-1:0] X_INIT = dfr_pkg::TRIG_W'(652032874);

    logic signed [dfr_pkg::TRIG_W-1:0] x_reg, y_reg;
    logic signed [31:0]                z_reg;
    logic [1:0]                        q_reg;
    logic [dfr_pkg::STEP_W-1:0]        i_reg;
    logic                              busy_reg, done_reg;

    logic signed [dfr_pkg::TRIG_W-1:0] sx, sy;
    logic signed [31:0]                at;

    assign sx = x_reg >>> i_reg;
    assign sy = y_reg >>> i_reg;
    assign at = $signed(dfr_pkg::atan_turn(i_reg));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                i_reg    <= '0;
                x_reg    <= X_INIT;
                y_reg    <= '0;
                // fold to [-1/8, 1/8) turn, carry into the quadrant
                q_reg    <= angle[31:30] + {1'b0, angle[29]};
                z_reg    <= $signed({2'b00, angle[29:0]}) - (angle[29] ? 32'sh4000_0000 : 32'sd0);
            end else if (busy_reg) begin
                if (!z_reg[31]) begin
                    x_reg <= x_reg - sy;
                    y_reg <= y_reg + sx;
                    z_reg <= z_reg - at;
                end else begin
                    x_reg <= x_reg + sy;
                    y_reg <= y_reg - sx;
                    z_reg <= z_reg + at;
                end
                i_reg <= i_reg + 1'b1;
                if (i_reg == dfr_pkg::STEP_W'(dfr_pkg::CORDIC_STEPS - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_comb begin
        unique case (q_reg)
            2'd0: begin cos_out = x_reg;  sin_out = y_reg;  end
            2'd1: begin cos_out = -y_reg; sin_out = x_reg;  end
            2'd2: begin cos_out = -x_reg; sin_out = -y_reg; end
            default: begin cos_out = y_reg; sin_out = -x_reg; end
        endcase
    end

    assign done = done_reg;

endmodule
`default_nettype wire

### hw/rtl/dfr_divider.sv
// Restoring divider giving a rounded, saturated Q16.16 quotient, one bit per cycle.
`timescale 1ns / 1ps
`default_nettype none
module dfr_divider (
    input  wire logic                                 aclk,
    input  wire logic                                 aresetn,
    input  wire logic                                 start,
    input  wire logic signed [dfr_pkg::HNUM_W-1:0]    num,
    input  wire logic        [dfr_pkg::DEN_W-1:0]     den,
    output logic                                      done,
    output logic signed [dfr_pkg::RES_W-1:0]          quo
);

    localparam int QB  = 33;           // 16 integer bits, 17 fraction bits
    localparam int CW  = $clog2(QB + 1);
    localparam int RW  = dfr_pkg::DEN_W + 1;
    localparam int CMPW = dfr_pkg::HNUM_W + 16;

    logic [dfr_pkg::HNUM_W-1:0] mag;
    logic [RW-1:0]              rem_reg, trial;
    logic [QB-1:0]              sh_reg, q_reg;
    logic [dfr_pkg::DEN_W-1:0]  d_reg;
    logic [CW-1:0]              cnt_reg;
    logic                       busy_reg, done_reg, neg_reg, sat_reg;
    logic [QB:0]                res;

    assign mag   = num[dfr_pkg::HNUM_W-1] ? dfr_pkg::HNUM_W'(-num) : dfr_pkg::HNUM_W'(num);
    assign trial = {rem_reg[RW-2:0], sh_reg[QB-1]};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= CW'(QB);
                neg_reg  <= num[dfr_pkg::HNUM_W-1];
                // integer part of 2^16 or more saturates
                sat_reg  <= (CMPW'(mag) >= (CMPW'(den) << 16));
                rem_reg  <= RW'(mag >> 16);
                sh_reg   <= {mag[15:0], 17'b0};
                d_reg    <= den;
                q_reg    <= '0;
            end else if (busy_reg) begin
                if (trial >= {1'b0, d_reg}) begin
                    rem_reg <= trial - {1'b0, d_reg};
                    q_reg   <= {q_reg[QB-2:0], 1'b1};
                end else begin
                    rem_reg <= trial;
                    q_reg   <= {q_reg[QB-2:0], 1'b0};
                end
                sh_reg  <= {sh_reg[QB-2:0], 1'b0};
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CW'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_comb begin
        if (sat_reg) begin
            res = (QB + 1)'(34'h1_0000_0000);
        end else begin
            res = ({1'b0, q_reg} + 1'b1) >> 1;
        end
        if (neg_reg) begin
            if (res > (QB + 1)'(34'h0_8000_0000)) begin
                quo = 32'sh8000_0000;
            end else begin
                quo = -$signed(res[dfr_pkg::RES_W-1:0]);
            end
        end else begin
            if (res > (QB + 1)'(34'h0_7FFF_FFFF)) begin
                quo = 32'sh7FFF_FFFF;
            end else begin
                quo = $signed(res[dfr_pkg::RES_W-1:0]);
            end
        end
    end

    assign done = done_reg;

endmodule
`default_nettype wire
